// File: rtl/nscr_pkg.sv
// Package: shared constants, controller/datapath command and status types, hex helper.
`default_nettype none
package nscr_pkg;

    localparam int RX_W  = 8;
    localparam int LEN_W = 6;

    localparam logic [RX_W-1:0] CH_START = 8'h24;
    localparam logic [RX_W-1:0] CH_CR    = 8'h0D;
    localparam logic [RX_W-1:0] CH_STAR  = 8'h2A;
    localparam int              TRAILER  = 3;

    typedef struct packed {
        logic store;
        logic idx_clear;
        logic chk_start;
        logic rd_en;
        logic chk_eval;
        logic cnt_clear;
        logic cnt_inc;
        logic out_load;
    } nscr_cmd_t;

    typedef struct packed {
        logic is_start;
        logic is_cr;
        logic frame_long;
        logic chk_last;
        logic sum_ok;
        logic em_last;
        logic out_free;
    } nscr_stat_t;

    function automatic logic [RX_W-1:0] hex_upper(input logic [3:0] nib);
        logic [RX_W-1:0] ch;
        if (nib < 4'd10)
            ch = 8'h30 + {4'd0, nib};
        else
            ch = 8'h41 + {4'd0, nib} - 8'd10;
        return ch;
    endfunction

endpackage
`default_nettype wire

// File: rtl/nscr_if.sv
// Interfaces: received byte channel and body result channel.
`default_nettype none
interface nscr_in_if
    import nscr_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [RX_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nscr_out_if
    import nscr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RX_W-1:0]  body_byte;
    logic [LEN_W-1:0] body_length;
    logic             is_last;

    modport source (output valid, output body_byte, output body_length, output is_last,
                    input ready);
    modport sink   (input valid, input body_byte, input body_length, input is_last,
                    output ready);
endinterface
`default_nettype wire

// File: rtl/nmea_sentence_checksum_receiver_core.sv
// Top level: NMEA sentence checksum receiver core.
// Channels: rx (sink) takes one received byte per request; body (source)
// gives one body byte per request with the body length and a last marker.
// Ordinary bytes and '$' are taken in the idle state; rx stays ready.
// A carriage return on more than three stored bytes starts a checksum walk
// over the buffer, a read state and an evaluate state per byte, set by the
// single read port of the sentence buffer; rx is not ready during the walk.
// On a checksum match the body is read back out, each byte through a read
// state and a load state; rx stays not ready until the last body byte is
// loaded into the output register.
// A held output register stalls emission; a byte may be taken on rx while
// the final result still waits on body.
// Reset clears the write index, the controller and the output valid;
// the buffer needs no clearing.
`default_nettype none
module nmea_sentence_checksum_receiver_core
    import nscr_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    nscr_in_if.sink     rx,
    nscr_out_if.source  body
);

    nscr_cmd_t  cmd;
    nscr_stat_t stat;

    nscr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nscr_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx.rx_byte),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (body.ready),
        .out_valid   (body.valid),
        .body_byte   (body.body_byte),
        .body_length (body.body_length),
        .is_last     (body.is_last)
    );

endmodule
`default_nettype wire

// File: rtl/nscr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module nscr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/nscr_ctrl.sv
// Controller: sequences byte intake, checksum walk and body emission.
`default_nettype none
module nscr_ctrl
    import nscr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire nscr_stat_t stat,
    output nscr_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHK_RD  = 3'd1;
    localparam logic [2:0] S_CHK_EV  = 3'd2;
    localparam logic [2:0] S_CHK_END = 3'd3;
    localparam logic [2:0] S_EM_RD   = 3'd4;
    localparam logic [2:0] S_EM_LD   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (stat.is_start)
                    begin
                        cmd.idx_clear = 1'b1;
                    end
                    else if (stat.is_cr)
                    begin
                        if (stat.frame_long)
                        begin
                            cmd.chk_start = 1'b1;
                            state_next    = S_CHK_RD;
                        end
                        else
                        begin
                            cmd.idx_clear = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            S_CHK_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CHK_EV;
            end
            S_CHK_EV:
            begin
                cmd.chk_eval = 1'b1;
                cmd.cnt_inc  = 1'b1;
                state_next   = stat.chk_last ? S_CHK_END : S_CHK_RD;
            end
            S_CHK_END:
            begin
                cmd.cnt_clear = 1'b1;
                if (stat.sum_ok)
                begin
                    state_next = S_EM_RD;
                end
                else
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EM_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_EM_LD;
            end
            S_EM_LD:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    if (stat.em_last)
                    begin
                        cmd.idx_clear = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/nscr_dp.sv
// Datapath: sentence buffer, write index, checksum accumulator and output register.
`default_nettype none
module nscr_dp
    import nscr_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [RX_W-1:0]   rx_byte,
    input  wire nscr_cmd_t         cmd,
    output nscr_stat_t             stat,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [RX_W-1:0]        body_byte,
    output logic [LEN_W-1:0]       body_length,
    output logic                   is_last
);

    localparam int IW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);

    logic [IW-1:0]   idx_reg;
    logic [IW-1:0]   idx_next;
    logic [IW-1:0]   idx_eff;
    logic [IW-1:0]   cnt_reg;
    logic [IW-1:0]   len;
    logic [RX_W-1:0] xor_reg;
    logic            ok_reg;
    logic            out_valid_reg;
    logic [RX_W-1:0] rd_data;

    assign idx_eff = (idx_reg == IW'(MAX_LEN)) ? '0 : idx_reg;
    assign len     = idx_reg - IW'(TRAILER);

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.store)
        begin
            idx_next = idx_eff + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.chk_start || cmd.cnt_clear)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + IW'(1);
        end
        if (cmd.chk_start)
        begin
            xor_reg <= '0;
            ok_reg  <= 1'b1;
        end
        else if (cmd.chk_eval)
        begin
            if (cnt_reg < len)
            begin
                xor_reg <= xor_reg ^ rd_data;
            end
            else if (cnt_reg == len)
            begin
                ok_reg <= ok_reg & (rd_data == CH_STAR);
            end
            else if (cnt_reg == len + IW'(1))
            begin
                ok_reg <= ok_reg & (rd_data == hex_upper(xor_reg[7:4]));
            end
            else
            begin
                ok_reg <= ok_reg & (rd_data == hex_upper(xor_reg[3:0]));
            end
        end
        if (cmd.out_load)
        begin
            body_byte   <= rd_data;
            body_length <= LEN_W'(len);
            is_last     <= stat.em_last;
        end
    end

    nscr_ram #(
        .WIDTH (RX_W),
        .DEPTH (MAX_LEN)
    ) u_buf (
        .clk     (clk),
        .wr_en   (cmd.store),
        .wr_addr (idx_eff[AW-1:0]),
        .wr_data (rx_byte),
        .rd_en   (cmd.rd_en),
        .rd_addr (cnt_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign stat.is_start   = (rx_byte == CH_START);
    assign stat.is_cr      = (rx_byte == CH_CR);
    assign stat.frame_long = (idx_eff > IW'(TRAILER));
    assign stat.chk_last   = (cnt_reg == idx_reg - IW'(1));
    assign stat.sum_ok     = ok_reg;
    assign stat.em_last    = (cnt_reg == len - IW'(1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire
